// ----- hw/rtl/sr_pkg.sv -----
// Shared types, constants and helpers for the selective-repeat receiver.
// No dependencies; imported by every module of the block.
package sr_pkg;

  localparam int WINDOW_SLOTS_DEF = 8;
  localparam int SEQ_SPACE_DEF    = 16;

  localparam int SEQ_W      = 24;
  localparam int ACK_W      = 25;
  localparam int SUM_W      = 32;
  localparam int ACK_CSUM_W = 25;
  localparam int BSUM_W     = 11;   // sum of eight bytes

  // ack checksum is seq plus twenty ascii '0' bytes
  localparam int PAYLOAD_BYTES   = 20;
  localparam int ASCII_ZERO      = 48;
  localparam int ACK_CSUM_OFFSET = PAYLOAD_BYTES * ASCII_ZERO;

  // seq+ack, then the low, mid and high payload words
  localparam int SUM_STEPS = 4;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef struct packed {
    logic [31:0] high;
    logic [63:0] mid;
    logic [63:0] low;
  } payload_t;

  typedef struct packed {
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             carry;   // set on subtract when a >= b
  } alu_rsp_t;

  function automatic logic [BSUM_W-1:0] byte_sum(input logic [63:0] v);
    logic [BSUM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + BSUM_W'(v[8*i +: 8]);
    end
    return s;
  endfunction

endpackage

// ----- hw/rtl/sr_alu.sv -----
// Shared 32-bit add/subtract unit used for the checksum, compare and modulo steps.
// Depends on sr_pkg for the request and response structs.
module sr_alu
  import sr_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [SUM_W-1:0] b_op;
  logic [SUM_W:0]   full;

  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{SUM_W{1'b0}}, req.sub};

  assign rsp.sum   = full[SUM_W-1:0];
  assign rsp.carry = full[SUM_W];

endmodule

// ----- hw/rtl/sr_payload_mem.sv -----
// Payload buffer of the receive window, one entry per slot, registered read.
// Depends on sr_pkg for payload_t.
module sr_payload_mem
  import sr_pkg::*;
#(
  parameter int DEPTH  = WINDOW_SLOTS_DEF,
  parameter int ADDR_W = $clog2(WINDOW_SLOTS_DEF)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  payload_t          wdata,
  input  logic [ADDR_W-1:0] raddr,
  output payload_t          rdata
);

  payload_t mem [DEPTH];
  payload_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-first on a same-address collision
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/selective_repeat_receiver.sv -----
// Selective-repeat receiver: checks each data packet's checksum, buffers in-window
// packets, acknowledges every good packet and delivers buffered payloads in order.
// Depends on sr_pkg, sr_alu and sr_payload_mem.
//
// One packet is taken at a time; in_stall stays high during reset and until the
// packet is dropped as corrupted or its last result has been loaded into the
// output register. The checksum, compare, slot and ack-checksum arithmetic runs
// through one shared 32-bit adder under a small sequencer: it builds the checksum
// from seq+ack and the payload words, compares it with the carried checksum, and
// a good in-window packet then takes three steps to find its slot (offset from
// the base, add the base slot, one compare and subtract). Each result is loaded
// into the output register once the output side is not stalling.
module selective_repeat_receiver
  import sr_pkg::*;
#(
  parameter int WINDOW_SLOTS = WINDOW_SLOTS_DEF,
  parameter int SEQ_SPACE    = SEQ_SPACE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SEQ_W-1:0]      in_seq_number,
  input  logic [ACK_W-1:0]      in_ack_field,
  input  logic [SUM_W-1:0]      in_packet_checksum,
  input  logic [63:0]           in_payload_low,
  input  logic [63:0]           in_payload_mid,
  input  logic [31:0]           in_payload_high,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_result_kind,
  output logic [SEQ_W-1:0]      out_ack_number,
  output logic [ACK_CSUM_W-1:0] out_ack_checksum,
  output logic [63:0]           out_deliver_low,
  output logic [63:0]           out_deliver_mid,
  output logic [31:0]           out_deliver_high,
  output logic                  out_last_of_run
);

  localparam int SLOT_W = $clog2(WINDOW_SLOTS);
  localparam int BASE_W = $clog2(SEQ_SPACE);
  localparam int TOP_W  = $clog2(SEQ_SPACE + WINDOW_SLOTS);
  localparam int REM_W  = $clog2(2 * WINDOW_SLOTS);
  localparam int CNT_W  = $clog2(WINDOW_SLOTS + 1);
  localparam int STEP_W = $clog2(SUM_STEPS);
  localparam int MOD_STEPS = 3;
  localparam int TOP_MOD_RST = WINDOW_SLOTS % SEQ_SPACE;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_CHECK, S_MOD, S_ACK, S_DELIV
  } state_t;

  state_t                 state_r;
  logic [SEQ_W-1:0]       seq_r;
  logic [ACK_W-1:0]       ack_r;
  logic [SUM_W-1:0]       carried_r;
  payload_t               pay_r;
  logic [SUM_W-1:0]       acc_r;
  logic [REM_W-1:0]       rem_r;
  logic [STEP_W-1:0]      step_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BASE_W-1:0]      base_r;
  logic [SLOT_W-1:0]      base_slot_r;
  logic [BASE_W-1:0]      top_mod_r;
  logic [WINDOW_SLOTS-1:0] rcv_r;

  logic                   out_valid_r;
  logic                   out_kind_r;
  logic [SEQ_W-1:0]       out_ack_num_r;
  logic [ACK_CSUM_W-1:0]  out_ack_csum_r;
  payload_t               out_pay_r;
  logic                   out_last_r;

  alu_req_t               alu_req;
  alu_rsp_t               alu_rsp;
  payload_t               mem_rdata;

  logic                   out_free;
  logic                   emit_ack;
  logic                   emit_dlv;
  logic [TOP_W-1:0]       top_full;
  logic                   top_ge_s;
  logic                   in_lower;
  logic                   in_win;
  logic [SLOT_W-1:0]      idx;
  logic                   mem_we;
  logic [BASE_W-1:0]      base_inc;
  logic [SLOT_W-1:0]      slot_inc;
  logic [BASE_W-1:0]      top_mod_inc;
  logic [SLOT_W-1:0]      base_slot_nxt;
  logic                   last_ack;
  logic                   last_dlv;
  logic                   in_take;

  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  assign out_free = !out_valid_r || !out_stall;
  assign emit_ack = (state_r == S_ACK) && out_free;
  assign emit_dlv = (state_r == S_DELIV) && out_free;

  // window test, seq compared at full width
  assign top_full = TOP_W'(base_r) + TOP_W'(WINDOW_SLOTS);
  assign top_ge_s = (top_full >= TOP_W'(SEQ_SPACE));
  assign in_lower = (seq_r >= SEQ_W'(base_r)) && (seq_r < SEQ_W'(top_full));
  assign in_win   = in_lower || (top_ge_s && (seq_r < SEQ_W'(top_mod_r)));

  assign idx = rem_r[SLOT_W-1:0];

  // base and slot pointer advance; slot restarts with the base on wrap
  always_comb begin
    if (base_r == BASE_W'(SEQ_SPACE - 1)) begin
      base_inc = '0;
      slot_inc = '0;
    end else begin
      base_inc = base_r + BASE_W'(1);
      slot_inc = (base_slot_r == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 :
                 base_slot_r + SLOT_W'(1);
    end
    top_mod_inc = (top_mod_r == BASE_W'(SEQ_SPACE - 1)) ? '0 : top_mod_r + BASE_W'(1);
  end

  assign base_slot_nxt = emit_dlv ? slot_inc : base_slot_r;

  assign mem_we   = emit_ack && in_win && !rcv_r[idx];
  assign last_ack = !in_win || !(rcv_r[base_slot_r] || (idx == base_slot_r));
  // the next slot can be the one being emptied when the base wraps
  assign last_dlv = !(rcv_r[slot_inc] && (slot_inc != base_slot_r) &&
                      (cnt_r < CNT_W'(WINDOW_SLOTS - 1)));

  always_comb begin
    alu_req = '0;
    unique case (state_r)
      S_SUM: begin
        unique case (step_r)
          STEP_W'(0): begin
            alu_req.a = SUM_W'(seq_r);
            alu_req.b = {{(SUM_W - ACK_W){ack_r[ACK_W-1]}}, ack_r};
          end
          STEP_W'(1): begin
            alu_req.a = acc_r;
            alu_req.b = SUM_W'(byte_sum(pay_r.low));
          end
          STEP_W'(2): begin
            alu_req.a = acc_r;
            alu_req.b = SUM_W'(byte_sum(pay_r.mid));
          end
          default: begin
            alu_req.a = acc_r;
            alu_req.b = SUM_W'(byte_sum(64'(pay_r.high)));
          end
        endcase
      end
      S_CHECK: begin
        alu_req.a   = acc_r;
        alu_req.b   = carried_r;
        alu_req.sub = 1'b1;
      end
      S_MOD: begin
        // slot = base slot + (seq - base), one compare and subtract;
        // a wrapped-window seq is already below the slot count
        unique case (step_r)
          STEP_W'(2): begin
            alu_req.a   = SUM_W'(seq_r);
            alu_req.b   = in_lower ? SUM_W'(base_r) : '0;
            alu_req.sub = 1'b1;
          end
          STEP_W'(1): begin
            alu_req.a = SUM_W'(rem_r);
            alu_req.b = in_lower ? SUM_W'(base_slot_r) : '0;
          end
          default: begin
            alu_req.a   = SUM_W'(rem_r);
            alu_req.b   = SUM_W'(WINDOW_SLOTS);
            alu_req.sub = 1'b1;
          end
        endcase
      end
      S_ACK: begin
        alu_req.a = SUM_W'(seq_r);
        alu_req.b = SUM_W'(ACK_CSUM_OFFSET);
      end
      default: alu_req = '0;
    endcase
  end

  sr_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  sr_payload_mem #(
    .DEPTH  (WINDOW_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (pay_r),
    .raddr (base_slot_nxt),
    .rdata (mem_rdata)
  );

  // sequencer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      base_r      <= '0;
      base_slot_r <= '0;
      top_mod_r   <= BASE_W'(TOP_MOD_RST);
      rcv_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_ack || emit_dlv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_SUM;
            step_r  <= '0;
          end
        end
        S_SUM: begin
          step_r <= step_r + STEP_W'(1);
          if (step_r == STEP_W'(SUM_STEPS - 1)) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (alu_rsp.sum != '0) begin
            state_r <= S_IDLE;          // corrupted, dropped silently
          end else if (in_win) begin
            state_r <= S_MOD;
            step_r  <= STEP_W'(MOD_STEPS - 1);
          end else begin
            state_r <= S_ACK;
          end
        end
        S_MOD: begin
          if (step_r == '0) begin
            state_r <= S_ACK;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_ACK: begin
          if (out_free) begin
            if (mem_we) begin
              rcv_r[idx] <= 1'b1;
            end
            cnt_r   <= '0;
            state_r <= last_ack ? S_IDLE : S_DELIV;
          end
        end
        S_DELIV: begin
          if (out_free) begin
            rcv_r[base_slot_r] <= 1'b0;
            base_r      <= base_inc;
            base_slot_r <= slot_inc;
            top_mod_r   <= top_mod_inc;
            cnt_r       <= cnt_r + CNT_W'(1);
            if (last_dlv) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      seq_r     <= in_seq_number;
      ack_r     <= in_ack_field;
      carried_r <= in_packet_checksum;
      pay_r     <= '{high: in_payload_high, mid: in_payload_mid, low: in_payload_low};
    end
    if (state_r == S_SUM) begin
      acc_r <= alu_rsp.sum;
    end
    if ((state_r == S_MOD) && ((step_r != '0) || alu_rsp.carry)) begin
      rem_r <= alu_rsp.sum[REM_W-1:0];
    end
    if (emit_ack) begin
      out_kind_r     <= KIND_ACK;
      out_ack_num_r  <= seq_r;
      out_ack_csum_r <= alu_rsp.sum[ACK_CSUM_W-1:0];
      out_pay_r      <= '0;
      out_last_r     <= last_ack;
    end
    if (emit_dlv) begin
      out_kind_r     <= KIND_DELIVER;
      out_ack_num_r  <= '0;
      out_ack_csum_r <= '0;
      out_pay_r      <= mem_rdata;
      out_last_r     <= last_dlv;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_ack_number   = out_ack_num_r;
  assign out_ack_checksum = out_ack_csum_r;
  assign out_deliver_low  = out_pay_r.low;
  assign out_deliver_mid  = out_pay_r.mid;
  assign out_deliver_high = out_pay_r.high;
  assign out_last_of_run  = out_last_r;

  // a delivery only ever reads a filled slot
  a_deliver_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DELIV) |-> rcv_r[base_slot_r])
    else $error("delivery from an empty slot");

  // slot index is fully reduced by the time the ack goes out
  a_slot_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ACK) && in_win) |-> (rem_r < REM_W'(WINDOW_SLOTS)))
    else $error("slot index not reduced");

  // incremental window top tracks the base
  a_top_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    top_mod_r == BASE_W'((TOP_W'(base_r) + TOP_W'(WINDOW_SLOTS)) % SEQ_SPACE))
    else $error("window top out of step with base");

  // every delivery moves the base
  a_base_moves: assert property (@(posedge clk) disable iff (!rst_n)
    emit_dlv |=> (base_r != $past(base_r)))
    else $error("base did not advance on delivery");

endmodule
